FILE: sv/rvsc_pkg.sv
package rvsc_pkg;

    localparam int XLEN          = 32;
    localparam int NREGS         = 32;
    localparam int REG_AW        = 5;
    localparam int PROGRAM_WORDS = 1024;
    localparam int PC_W          = $clog2(PROGRAM_WORDS);
    localparam int LEN_W         = PC_W + 1;
    localparam int MADDR_W       = 5;

    // Stream payload widths; the data widths are padded to whole bytes
    localparam int S_DATA_W = 72;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 48;

    typedef enum logic [1:0] {
        CMD_EXEC  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ALU_ADD = 3'd0,
        ALU_SLL = 3'd1,
        ALU_MUL = 3'd2,
        ALU_SUB = 3'd3,
        ALU_XOR = 3'd4,
        ALU_SRL = 3'd5,
        ALU_OR  = 3'd6,
        ALU_AND = 3'd7
    } alu_op_t;

    localparam logic [6:0] OP_R   = 7'b0110011;
    localparam logic [6:0] OP_I   = 7'b0010011;
    localparam logic [6:0] OP_L   = 7'b0000011;
    localparam logic [6:0] OP_S   = 7'b0100011;
    localparam logic [6:0] OP_J   = 7'b1101111;
    localparam logic [6:0] OP_B   = 7'b1100011;
    localparam logic [6:0] OP_LUI = 7'b0110111;

    localparam logic [2:0] BR_EQ  = 3'b000;
    localparam logic [2:0] BR_NE  = 3'b001;
    localparam logic [2:0] BR_LT  = 3'b100;
    localparam logic [2:0] BR_GE  = 3'b101;
    localparam logic [2:0] BR_LTU = 3'b110;
    localparam logic [2:0] BR_GEU = 3'b111;

endpackage

FILE: sv/rvsc_ram.sv
module rvsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read-first: a read at the address being written returns the old word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/rvsc_alu.sv
module rvsc_alu (
    input  rvsc_pkg::alu_op_t       op,
    input  logic [rvsc_pkg::XLEN-1:0] a,
    input  logic [rvsc_pkg::XLEN-1:0] b,
    output logic [rvsc_pkg::XLEN-1:0] y
);
    import rvsc_pkg::*;

    logic [4:0]      sh;
    logic [XLEN-1:0] prod;

    assign sh   = b[4:0];
    assign prod = a * b;

    always_comb begin
        unique case (op)
            ALU_ADD: y = a + b;
            ALU_SLL: y = a << sh;
            ALU_MUL: y = prod;
            ALU_SUB: y = a - b;
            ALU_XOR: y = a ^ b;
            ALU_SRL: y = a >> sh;
            ALU_OR:  y = a | b;
            ALU_AND: y = a & b;
            default: y = a + b;
        endcase
    end

endmodule

FILE: sv/rv32_subset_core_step.sv
// Single-step core for a small RV32I-like integer subset. Each input item is one command:
// execute the instruction in s_tdata at the current program counter, write a data memory
// word, read one, or do nothing; every item returns exactly one result item with the
// new pc, the halt flag, the value written back or read, and fault flags. The pc counts
// instructions and wraps at 1024; the core is halted while pc >= program_length, and
// execute items are ignored then. The block takes one item per clock unless the output
// is stalled, and keeps taking items while earlier ones are in flight; a result passes
// operand read, execute/memory access and write-back into the output register. The rate
// is set by the register file and data memory, synchronous RAMs: the register file is
// read when an item is taken, data memory is accessed in the execute stage, and the
// register file is written in the write-back stage, with forwarding from write-back and
// from the last write so that back-to-back dependent instructions need no stall. After
// reset a clearing pass zeroes both memories, one entry per cycle, max(DATA_WORDS, 32)
// entries, s_tready stays low until it ends, and program_length may be written meanwhile.
module rv32_subset_core_step #(
    parameter int DATA_WORDS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration: program_length
    input  logic                           cfg_wr_en,
    input  logic [rvsc_pkg::LEN_W-1:0]     cfg_wr_data,
    // input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [31:0] instr, [36:32] mem_addr, [68:37] mem_wdata, [71:69] zero
    input  logic [rvsc_pkg::S_DATA_W-1:0]  s_tdata,
    // [1:0] cmd
    input  logic [rvsc_pkg::S_USER_W-1:0]  s_tuser,
    // result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [9:0] next_pc, [10] halted, [42:11] data_out, [43] reg_written,
    // [44] mem_fault, [47:45] zero
    output logic [rvsc_pkg::M_DATA_W-1:0]  m_tdata
);
    import rvsc_pkg::*;

    localparam int DM_AW     = $clog2(DATA_WORDS);
    localparam int CLR_DEPTH = (DATA_WORDS > NREGS) ? DATA_WORDS : NREGS;
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    // ------------------------------------------------------------------
    // Control and clearing pass
    // ------------------------------------------------------------------
    logic             adv;
    logic             s_accept;
    logic             clr_busy_reg;
    logic [CLR_W-1:0] clr_cnt_reg;
    logic [LEN_W-1:0] prog_len_reg;
    logic [PC_W-1:0]  pc_reg;
    logic [PC_W-1:0]  pc_next;

    logic             m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    // The whole pipeline moves when the output register is free or being drained
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv && !clr_busy_reg;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
            if (32'(clr_cnt_reg) == 32'(CLR_DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prog_len_reg <= '0;
        end else if (cfg_wr_en) begin
            prog_len_reg <= cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Register file: two copies, one per read port, written together
    // ------------------------------------------------------------------
    logic              rf_we;
    logic [REG_AW-1:0] rf_waddr;
    logic [XLEN-1:0]   rf_wdata;
    logic [XLEN-1:0]   rf1_rdata;
    logic [XLEN-1:0]   rf2_rdata;
    logic [XLEN-1:0]   s_instr;

    assign s_instr = s_tdata[XLEN-1:0];

    rvsc_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_rf1 (
        .aclk  (aclk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (s_accept),
        .raddr (s_instr[19:15]),
        .rdata (rf1_rdata)
    );

    rvsc_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_rf2 (
        .aclk  (aclk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (s_accept),
        .raddr (s_instr[24:20]),
        .rdata (rf2_rdata)
    );

    // ------------------------------------------------------------------
    // Execute stage registers
    // ------------------------------------------------------------------
    logic                s1_valid_reg;
    cmd_t                s1_cmd_reg;
    logic [XLEN-1:0]     s1_instr_reg;
    logic [MADDR_W-1:0]  s1_maddr_reg;
    logic [XLEN-1:0]     s1_wdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_cmd_reg   <= cmd_t'(s_tuser[1:0]);
            s1_instr_reg <= s_instr;
            s1_maddr_reg <= s_tdata[XLEN +: MADDR_W];
            s1_wdata_reg <= s_tdata[XLEN+MADDR_W +: XLEN];
        end
    end

    // ------------------------------------------------------------------
    // Write-back stage registers and last-write bypass
    // ------------------------------------------------------------------
    logic              s2_valid_reg;
    logic [REG_AW-1:0] s2_rd_reg;
    logic              s2_we_reg;
    logic              s2_use_mem_reg;
    logic [XLEN-1:0]   s2_val_reg;
    logic              s2_fault_reg;
    logic [PC_W-1:0]   s2_pc_reg;
    logic              s2_halted_reg;
    logic [XLEN-1:0]   s2_result;

    logic              lw_valid_reg;
    logic [REG_AW-1:0] lw_rd_reg;
    logic [XLEN-1:0]   lw_val_reg;

    logic [XLEN-1:0]   dm_rdata;

    // Load data and host reads come straight off the memory output
    assign s2_result = s2_use_mem_reg ? dm_rdata : s2_val_reg;

    // ------------------------------------------------------------------
    // Execute: decode, operand forwarding, ALU, branch, memory access
    // ------------------------------------------------------------------
    logic [6:0]        op;
    logic [REG_AW-1:0] rd;
    logic [REG_AW-1:0] rs1;
    logic [REG_AW-1:0] rs2;
    logic [2:0]        f3;
    logic [XLEN-1:0]   opa;
    logic [XLEN-1:0]   opb;
    logic [XLEN-1:0]   imm_i;
    logic [XLEN-1:0]   imm_s;
    logic [PC_W-1:0]   imm_j;
    logic [XLEN-1:0]   alu_b;
    logic [XLEN-1:0]   alu_y;
    logic [XLEN-1:0]   ea;
    logic              ea_ok;
    logic              host_ok;
    logic              exec;
    logic              take;
    logic [PC_W-1:0]   pc_plus1;
    logic [PC_W-1:0]   new_pc;
    logic              x_we;
    logic              x_use_mem;
    logic [XLEN-1:0]   x_val;
    logic              x_fault;

    logic              dm_we;
    logic [DM_AW-1:0]  dm_waddr;
    logic [XLEN-1:0]   dm_wdata;
    logic              dm_re;
    logic [DM_AW-1:0]  dm_raddr;
    logic [XLEN-1:0]   acc_addr;

    assign op    = s1_instr_reg[6:0];
    assign rd    = s1_instr_reg[11:7];
    assign f3    = s1_instr_reg[14:12];
    assign rs1   = s1_instr_reg[19:15];
    assign rs2   = s1_instr_reg[24:20];
    assign imm_i = {{20{s1_instr_reg[31]}}, s1_instr_reg[31:20]};
    assign imm_s = {{20{s1_instr_reg[31]}}, s1_instr_reg[31:25], s1_instr_reg[11:7]};
    // Only the low pc bits of the jump offset matter since pc wraps
    assign imm_j = s1_instr_reg[12 +: PC_W];

    // x0 reads zero; newest write wins: write-back stage, then the last write
    always_comb begin
        priority if (rs1 == '0) begin
            opa = '0;
        end else if (s2_valid_reg && s2_we_reg && s2_rd_reg == rs1) begin
            opa = s2_result;
        end else if (lw_valid_reg && lw_rd_reg == rs1) begin
            opa = lw_val_reg;
        end else begin
            opa = rf1_rdata;
        end
        priority if (rs2 == '0) begin
            opb = '0;
        end else if (s2_valid_reg && s2_we_reg && s2_rd_reg == rs2) begin
            opb = s2_result;
        end else if (lw_valid_reg && lw_rd_reg == rs2) begin
            opb = lw_val_reg;
        end else begin
            opb = rf2_rdata;
        end
    end

    assign alu_b = (op == OP_I) ? imm_i : opb;

    rvsc_alu u_alu (
        .op (alu_op_t'(f3)),
        .a  (opa),
        .b  (alu_b),
        .y  (alu_y)
    );

    assign exec     = (s1_cmd_reg == CMD_EXEC) && (LEN_W'(pc_reg) < prog_len_reg);
    assign ea       = opa + ((op == OP_L) ? imm_i : imm_s);
    assign ea_ok    = !ea[XLEN-1] && (ea < XLEN'(DATA_WORDS));
    assign host_ok  = XLEN'(s1_maddr_reg) < XLEN'(DATA_WORDS);
    assign pc_plus1 = pc_reg + PC_W'(1);

    always_comb begin
        unique case (f3)
            BR_EQ:   take = (opa == opb);
            BR_NE:   take = (opa != opb);
            BR_LT:   take = ($signed(opa) < $signed(opb));
            BR_GE:   take = ($signed(opa) >= $signed(opb));
            BR_LTU:  take = (opa < opb);
            BR_GEU:  take = (opa >= opb);
            default: take = 1'b0;
        endcase
    end

    always_comb begin
        new_pc    = pc_reg;
        x_we      = 1'b0;
        x_use_mem = 1'b0;
        x_val     = '0;
        x_fault   = 1'b0;
        unique case (s1_cmd_reg)
            CMD_WRITE: begin
                x_fault = !host_ok;
            end
            CMD_READ: begin
                x_fault   = !host_ok;
                x_use_mem = host_ok;
            end
            CMD_EXEC: begin
                if (exec) begin
                    new_pc = pc_plus1;
                    unique case (op)
                        OP_R, OP_I: begin
                            x_we  = (rd != '0);
                            x_val = x_we ? alu_y : '0;
                        end
                        OP_L: begin
                            // a faulting load still writes zero to rd
                            x_we      = (rd != '0);
                            x_use_mem = x_we && ea_ok;
                            x_fault   = !ea_ok;
                        end
                        OP_S: begin
                            x_fault = !ea_ok;
                        end
                        OP_J: begin
                            x_we   = (rd != '0);
                            x_val  = x_we ? XLEN'(pc_plus1) : '0;
                            new_pc = pc_reg + imm_j;
                        end
                        OP_B: begin
                            if (take) begin
                                new_pc = pc_reg + imm_s[PC_W-1:0];
                            end
                        end
                        default: begin
                            // upper immediate and unknown opcodes: advance only
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    assign pc_next = new_pc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= '0;
        end else if (adv && s1_valid_reg && exec) begin
            pc_reg <= pc_next;
        end
    end

    // Data memory: every item's access happens in the execute stage, in item order
    assign acc_addr = (s1_cmd_reg == CMD_EXEC) ? ea : XLEN'(s1_maddr_reg);

    always_comb begin
        dm_re    = adv && s1_valid_reg;
        dm_raddr = acc_addr[DM_AW-1:0];
        if (clr_busy_reg) begin
            dm_we    = 32'(clr_cnt_reg) < 32'(DATA_WORDS);
            dm_waddr = clr_cnt_reg[DM_AW-1:0];
            dm_wdata = '0;
        end else begin
            dm_we    = adv && s1_valid_reg &&
                       (((s1_cmd_reg == CMD_WRITE) && host_ok) ||
                        (exec && (op == OP_S) && ea_ok));
            dm_waddr = acc_addr[DM_AW-1:0];
            dm_wdata = (s1_cmd_reg == CMD_WRITE) ? s1_wdata_reg : opb;
        end
    end

    rvsc_ram #(.WIDTH(XLEN), .DEPTH(DATA_WORDS)) u_dmem (
        .aclk  (aclk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .re    (dm_re),
        .raddr (dm_raddr),
        .rdata (dm_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && s1_valid_reg) begin
            s2_rd_reg      <= rd;
            s2_we_reg      <= x_we;
            s2_use_mem_reg <= x_use_mem;
            s2_val_reg     <= x_val;
            s2_fault_reg   <= x_fault;
            s2_pc_reg      <= new_pc;
            s2_halted_reg  <= LEN_W'(new_pc) >= prog_len_reg;
        end
    end

    // ------------------------------------------------------------------
    // Write-back: register file write, bypass capture, output register
    // ------------------------------------------------------------------
    always_comb begin
        if (clr_busy_reg) begin
            rf_we    = 32'(clr_cnt_reg) < 32'(NREGS);
            rf_waddr = clr_cnt_reg[REG_AW-1:0];
            rf_wdata = '0;
        end else begin
            rf_we    = adv && s2_valid_reg && s2_we_reg;
            rf_waddr = s2_rd_reg;
            rf_wdata = s2_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lw_valid_reg <= 1'b0;
        end else if (!clr_busy_reg && rf_we) begin
            lw_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!clr_busy_reg && rf_we) begin
            lw_rd_reg  <= rf_waddr;
            lw_val_reg <= rf_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && s2_valid_reg) begin
            m_data_reg <= {3'b000, s2_fault_reg, s2_we_reg, s2_result,
                           s2_halted_reg, s2_pc_reg};
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // No item may enter while the memories are being cleared
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !s_tready)
        else $error("item accepted during clearing pass");

    // x0 is never written by the pipeline
    a_no_x0_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (rf_we && !clr_busy_reg) |-> (rf_waddr != '0))
        else $error("write to x0");

    // pc moves only when an executing instruction leaves the execute stage
    a_pc_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(adv && s1_valid_reg && exec) |=> $stable(pc_reg))
        else $error("pc changed without an executed instruction");

    // Data memory is written only while the pipeline advances or clears
    a_dmem_write_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        (dm_we && !clr_busy_reg) |-> (adv && s1_valid_reg))
        else $error("data memory written during a stall");

endmodule
